// File: design/mlft_pkg.sv
package mlft_pkg;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 3;

    // one frame header beat
    typedef struct packed {
        logic [MAC_W-1:0]  target_mac;
        logic [MAC_W-1:0]  source_mac;
        logic [PORT_W-1:0] arrival_port;
    } in_item_t;

    // one forwarding decision beat
    typedef struct packed {
        logic              flood;
        logic [PORT_W-1:0] egress_port;
        logic              learn_dropped;
    } out_item_t;

endpackage

// File: design/mlft_cam.sv
module mlft_cam
    import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int PORT_COUNT    = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [MAC_W-1:0]  mac_reg  [TABLE_ENTRIES];
    logic [PORT_W-1:0] port_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;

    logic [TABLE_ENTRIES-1:0] src_hit;
    logic [TABLE_ENTRIES-1:0] dst_hit;
    logic [PORT_W-1:0] dst_port;
    logic src_known;
    logic port_ok;
    logic table_full;
    logic learn_new;
    logic learn_upd;
    logic dropped;
    logic [IDX_W-1:0] free_idx;

    // parallel compare of every entry against both keys
    always_comb
    begin
        dst_port = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            src_hit[i] = valid_reg[i] && (mac_reg[i] == item.source_mac);
            dst_hit[i] = valid_reg[i] && (mac_reg[i] == item.target_mac);
            // keys are unique in the table, so at most one hit
            dst_port = dst_port | (dst_hit[i] ? port_reg[i] : '0);
        end
    end

    // entries are never freed, so the lowest free entry is the fill count
    assign free_idx   = fill_count_reg[IDX_W-1:0];
    assign src_known  = |src_hit;
    assign port_ok    = 32'(item.arrival_port) < PORT_COUNT;
    assign table_full = fill_count_reg == CNT_W'(TABLE_ENTRIES);
    assign learn_upd  = port_ok && src_known;
    assign learn_new  = port_ok && !src_known && !table_full;
    assign dropped    = port_ok && !src_known && table_full;

    // lookup sees the entry learned by this same beat
    always_comb
    begin
        result.learn_dropped = dropped;
        if ((learn_new || learn_upd) && (item.target_mac == item.source_mac))
        begin
            result.flood       = 1'b0;
            result.egress_port = item.arrival_port;
        end
        else if (|dst_hit)
        begin
            result.flood       = 1'b0;
            result.egress_port = dst_port;
        end
        else
        begin
            result.flood       = 1'b1;
            result.egress_port = '0;
        end
    end

    always_comb
    begin
        valid_next      = valid_reg;
        fill_count_next = fill_count_reg;
        if (step && learn_new)
        begin
            valid_next[free_idx] = 1'b1;
            fill_count_next      = fill_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            fill_count_reg <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            fill_count_reg <= fill_count_next;
        end
    end

    // key and port storage
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (learn_upd && src_hit[i])
                begin
                    port_reg[i] <= item.arrival_port;
                end
            end
            if (learn_new)
            begin
                mac_reg[free_idx]  <= item.source_mac;
                port_reg[free_idx] <= item.arrival_port;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count past table size");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(fill_count_reg))
        else $error("valid bits disagree with fill count");

    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        step && dropped |=> fill_count_reg == CNT_W'(TABLE_ENTRIES))
        else $error("learn dropped while entries free");

endmodule

// File: design/mac_learning_forward_table.sv
// layer-2 learning bridge address table
//
// in channel: in_valid / in_ready / in_data, one frame header per beat
// (destination mac, source mac, arrival port)
// out channel: out_valid / out_ready / out_data, one decision per beat
// (flood, egress port, learn dropped)
//
// each header is registered, then the source is learned into the cam and
// the destination looked up in the same cycle, the lookup seeing that learn;
// the decision lands in an output register
// a header thus passes the input register and then the output register
// before its decision beat goes out
// throughput: 1 beat per cycle while out_ready stays high, as the cam
// compares and writes all TABLE_ENTRIES entries in the same cycle
//
// reset clears all entry valid bits and the fill count at once, so the
// table is empty right after reset with no clearing pass
// when out_ready is low, the result waits in the output register and one
// more header is held in the input register; in_ready then drops
module mac_learning_forward_table
    import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int PORT_COUNT    = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t cam_result;
    logic      advance;
    logic      in_take;

    // the held header moves on when the output register is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    mlft_cam #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    ) u_cam (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .result (cam_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= cam_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_flood_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.flood |-> out_data.egress_port == '0)
        else $error("flood with nonzero egress port");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in pipeline");

    // a stalled decision beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("decision beat changed while stalled");

endmodule

// File: tb/mac_learning_forward_table_test.sv
`timescale 1ns / 100ps

module mac_learning_forward_table_test;
    import mlft_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_COUNT    = 8;
    localparam int POOL_SIZE     = 96;
    localparam int PRINT_CAP     = 30;

    // shadow copy of the address table plus the decisions still owed by the dut
    class bridge_scoreboard;
        logic [MAC_W-1:0]  shadow_mac   [TABLE_ENTRIES];
        logic [PORT_W-1:0] shadow_port  [TABLE_ENTRIES];
        bit                shadow_valid [TABLE_ENTRIES];
        out_item_t         pending_decisions[$];
        int                errors;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                shadow_mac[i]   = '0;
                shadow_port[i]  = '0;
                shadow_valid[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int lookup_slot(logic [MAC_W-1:0] mac);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (shadow_valid[i] && shadow_mac[i] == mac)
                    return i;
            return -1;
        endfunction

        function int lowest_free_slot();
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!shadow_valid[i])
                    return i;
            return -1;
        endfunction

        // learn the source, then look up the destination in the updated table
        function void learn_and_lookup(in_item_t hdr);
            out_item_t decision;
            int        slot;
            int        hit;
            decision = '0;
            if (int'(hdr.arrival_port) < PORT_COUNT)
            begin
                slot = lookup_slot(hdr.source_mac);
                if (slot < 0)
                    slot = lowest_free_slot();
                if (slot >= 0)
                begin
                    shadow_mac[slot]   = hdr.source_mac;
                    shadow_port[slot]  = hdr.arrival_port;
                    shadow_valid[slot] = 1'b1;
                end
                else
                    decision.learn_dropped = 1'b1;
            end
            hit = lookup_slot(hdr.target_mac);
            if (hit >= 0)
            begin
                decision.flood       = 1'b0;
                decision.egress_port = shadow_port[hit];
            end
            else
            begin
                decision.flood       = 1'b1;
                decision.egress_port = '0;
            end
            pending_decisions.push_back(decision);
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
        endtask

        task check_decision(out_item_t got);
            out_item_t want;
            if (pending_decisions.size() == 0)
            begin
                report("decision with none pending", int'(got), 0);
                return;
            end
            want = pending_decisions.pop_front();
            if (got.flood !== want.flood)
                report("flood", int'(got.flood), int'(want.flood));
            if (got.egress_port !== want.egress_port)
                report("egress_port", int'(got.egress_port), int'(want.egress_port));
            if (got.learn_dropped !== want.learn_dropped)
                report("learn_dropped", int'(got.learn_dropped), int'(want.learn_dropped));
        endtask

        function int pending_count();
            return pending_decisions.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    bridge_scoreboard sb;

    // set for the closing stretch: no gaps on the header side, no stalls on the result side
    bit calm_run;

    logic [MAC_W-1:0] mac_pool [POOL_SIZE];
    logic [MAC_W-1:0] last_source;

    mac_learning_forward_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #400000;
        $display("mac_learning_forward_table_test: done, errors");
        $finish;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    // hold valid until the beat is taken; the caller decides whether valid drops afterwards
    task automatic send_header(logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
                               logic [PORT_W-1:0] port);
        in_item_t hdr;
        hdr.target_mac   = dst;
        hdr.source_mac   = src;
        hdr.arrival_port = port;
        in_valid <= 1'b1;
        in_data  <= hdr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat accepted at this edge
        sb.learn_and_lookup(hdr);
        last_source = src;
    endtask

    // header, outside the calm stretch sometimes with a gap ahead of it
    task automatic offer(logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
                         logic [PORT_W-1:0] port);
        if (!calm_run && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        send_header(dst, src, port);
    endtask

    // mostly known addresses so the table fills and then stays full;
    // a slice of fresh random sources keeps hitting the full-table drop
    task automatic random_frame();
        logic [MAC_W-1:0] src;
        logic [MAC_W-1:0] dst;
        int               dsel;
        if ($urandom_range(0, 9) == 0)
            src = rand_mac();
        else
            src = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        dsel = $urandom_range(0, 19);
        if (dsel < 10)
            dst = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (dsel < 13)
            dst = src;                 // sees the learn of this very beat
        else if (dsel < 16)
            dst = rand_mac();          // almost surely unknown, floods
        else
            dst = last_source;
        offer(dst, src, PORT_W'($urandom_range(0, 7)));
    endtask

    // result side: random stall bursts, fully open during the calm stretch
    initial
    begin
        out_ready <= 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            if (!calm_run && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // every accepted decision beat is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_decision(out_data);
    end

    initial
    begin
        sb          = new();
        calm_run    = 1'b0;
        last_source = '0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        rst_n      <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, just-learned lookup, port moves, group addresses
        offer(48'h0, 48'h0, 3'd0);                               // all-zero key, hits itself
        offer(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd7);     // broadcast as a plain key
        offer(48'h0000_0000_1234, 48'h0010_2030_4050, 3'd3);     // unknown destination floods
        offer(48'h0010_2030_4050, 48'h0060_7080_90A0, 3'd5);     // hit on earlier learn
        offer(48'h0060_7080_90A0, 48'h0010_2030_4050, 3'd6);     // source moves to a new port
        offer(48'h0010_2030_4050, 48'h00B0_C0D0_E0F0, 3'd1);     // lookup sees the moved port
        offer(48'hFFFF_FFFF_FFFF, 48'h0100_5E00_0001, 3'd2);     // multicast source learned
        offer(48'h0100_5E00_0001, 48'hAAAA_AAAA_AAAA, 3'd4);
        offer(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 3'd3);
        offer(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 3'd0);
        offer(48'hAAAA_AAAA_AAAA, 48'h0, 3'd7);                  // zero key moves to port 7
        offer(48'h0, 48'h8000_0000_0000, 3'd6);
        offer(48'h8000_0000_0000, 48'h0000_0000_0001, 3'd5);
        offer(48'h0000_0000_0001, 48'h0000_0000_0001, 3'd1);     // same addresses twice, on a new port each time
        offer(48'h0000_0000_0001, 48'h0000_0000_0001, 3'd2);
        offer(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 3'd4);

        for (int i = 0; i < POOL_SIZE; i++)
            mac_pool[i] = rand_mac();
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        mac_pool[2] = 48'h0010_2030_4050;
        mac_pool[3] = 48'h0060_7080_90A0;
        mac_pool[4] = 48'h0100_5E00_0001;
        mac_pool[5] = 48'hAAAA_AAAA_AAAA;

        // first random stretch: the table fills up here
        for (int i = 0; i < 170; i++)
            random_frame();

        // sender holds off until every decision has come back
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);

        // second stretch: full table, port updates and dropped learns
        for (int i = 0; i < 170; i++)
            random_frame();

        // closing stretch at full rate on both sides
        calm_run = 1'b1;
        for (int i = 0; i < 60; i++)
            random_frame();

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);
        // let any stray late beat show up
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("mac_learning_forward_table_test: done, clean");
        else
            $display("mac_learning_forward_table_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
design/mlft_pkg.sv
design/mlft_cam.sv
design/mac_learning_forward_table.sv
tb/mac_learning_forward_table_test.sv
